### src/dbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_pkg: shared types and constants of the bounded deque
// Request and response item layouts, request and status codes, and the
// control codes that drive the row of storage cells.
// ----------------------------------------------------------------------------
package dbq_pkg;

	localparam int DEPTH_DEF     = 32;
	localparam int WORD_BITS_DEF = 32;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_COUNT      = 3'd4;
	localparam logic [2:0] REQ_READ       = 3'd5;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_EMPTY  = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;
	localparam logic [1:0] STATUS_BEYOND = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] data_word;
		logic [4:0]         position;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_word;
		logic [5:0]         match_count;
		logic [5:0]         occupancy;
	} rsp_item_t;

	// what the whole row does in one cycle
	typedef enum logic [1:0] {
		CHAIN_HOLD       = 2'd0,
		CHAIN_PUSH_FRONT = 2'd1,
		CHAIN_ROTATE     = 2'd2,
		CHAIN_WRITE_TAIL = 2'd3
	} chain_op_t;

	// what one cell does in one cycle
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_FROM_PREV = 2'd1,
		CELL_FROM_NEXT = 2'd2,
		CELL_LOAD      = 2'd3
	} cell_mode_t;

endpackage

### src/dbq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_cell: one storage cell of the deque row
// Holds one word and takes it from its neighbor on either side or from the
// load bus, as the mode says.
// ----------------------------------------------------------------------------
module dbq_cell #(
	parameter int WORD_BITS = dbq_pkg::WORD_BITS_DEF
) (
	input  logic                   clk,
	input  dbq_pkg::cell_mode_t    mode,
	input  logic [WORD_BITS-1:0]   load_word,
	input  logic [WORD_BITS-1:0]   prev_word,
	input  logic [WORD_BITS-1:0]   next_word,
	output logic [WORD_BITS-1:0]   word
);
	import dbq_pkg::*;

	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		unique case (mode)
			CELL_HOLD:      word_q <= word_q;
			CELL_FROM_PREV: word_q <= prev_word;
			CELL_FROM_NEXT: word_q <= next_word;
			CELL_LOAD:      word_q <= load_word;
			default:        word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

### src/dbq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_chain: ring of storage cells holding the deque entries
// The front entry sits in cell 0 and entry k in cell k. A push at the front
// shifts the row back, a rotation moves every word one cell toward the front
// and cell 0 wraps to the last cell.
// ----------------------------------------------------------------------------
module dbq_chain #(
	parameter int DEPTH     = dbq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = dbq_pkg::WORD_BITS_DEF,
	localparam int IDX_W    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  dbq_pkg::chain_op_t   op,
	input  logic [WORD_BITS-1:0] load_word,
	input  logic [IDX_W-1:0]     tail_idx,
	output logic [WORD_BITS-1:0] head_word
);
	import dbq_pkg::*;

	logic [WORD_BITS-1:0] words [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_mode_t mode;

		always_comb begin
			unique case (op)
				CHAIN_HOLD:       mode = CELL_HOLD;
				CHAIN_PUSH_FRONT: mode = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
				CHAIN_ROTATE:     mode = CELL_FROM_NEXT;
				CHAIN_WRITE_TAIL: mode = (tail_idx == IDX_W'(i)) ? CELL_LOAD : CELL_HOLD;
				default:          mode = CELL_HOLD;
			endcase
		end

		dbq_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk      (clk),
			.mode     (mode),
			.load_word(load_word),
			.prev_word(words[(i + DEPTH - 1) % DEPTH]),
			.next_word(words[(i + 1) % DEPTH]),
			.word     (words[i])
		);
	end

	assign head_word = words[0];

endmodule

### src/bounded_deque_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search: bounded double-ended queue with value search
// Request channel req_valid/req_ready/req carries one operation per item;
// response channel rsp_valid/rsp_ready/rsp returns exactly one item per
// request, in order: status, data word, match count and occupancy after it.
// Entries live in a ring of DEPTH cells with the front entry in cell 0.
// Push front, push back, pop front, rejected requests and unused codes are
// answered directly: the response is valid in the cycle after acceptance.
// Pop back, read at position and count matches rotate the ring once around,
// one cell per cycle, watching cell 0, then wait in a flush state until the
// response register is free and load the response there; the next request
// is taken after that, so no request is accepted while a scan is under way.
// The response sits in an output register; while the receiver stalls, the
// block holds it and takes no further request until it is drained.
// Reset empties the queue and the response register; cell contents are not
// cleared, and only written entries are ever returned.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
	parameter int DEPTH     = dbq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = dbq_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dbq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dbq_pkg::rsp_item_t rsp
);
	import dbq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [IDX_W-1:0]     step_q, step_d;
	logic [IDX_W-1:0]     target_q, target_d;
	logic [CNT_W-1:0]     acc_q, acc_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic [WORD_BITS-1:0] val_q;
	logic                 is_count_q, is_count_d;
	logic                 is_popb_q, is_popb_d;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q, rsp_d;
	logic                 rsp_load;

	chain_op_t            chain_op;
	logic [IDX_W-1:0]     tail_idx;
	logic [WORD_BITS-1:0] head_word;
	logic [WORD_BITS-1:0] req_word;
	logic                 rsp_free;
	logic                 accept;
	logic                 full;
	logic                 empty;

	dbq_chain #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_chain (
		.clk      (clk),
		.op       (chain_op),
		.load_word(req_word),
		.tail_idx (tail_idx),
		.head_word(head_word)
	);

	assign req_word  = WORD_BITS'(req.data_word);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && rsp_free;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign tail_idx  = IDX_W'(count_q);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		step_d     = step_q;
		target_d   = target_q;
		acc_d      = acc_q;
		word_d     = word_q;
		is_count_d = is_count_q;
		is_popb_d  = is_popb_q;
		chain_op   = CHAIN_HOLD;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		rsp_d.status = STATUS_OK;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rsp_load   = 1'b1;
					step_d     = '0;
					acc_d      = '0;
					word_d     = '0;
					is_count_d = 1'b0;
					is_popb_d  = 1'b0;
					unique case (req.req_type)
						REQ_PUSH_FRONT: begin
							if (full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								chain_op = CHAIN_PUSH_FRONT;
								count_d  = count_q + 1'b1;
							end
						end
						REQ_PUSH_BACK: begin
							if (full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								chain_op = CHAIN_WRITE_TAIL;
								count_d  = count_q + 1'b1;
							end
						end
						REQ_POP_FRONT: begin
							if (empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								// shift toward the front; the old head wraps past the count
								rsp_d.read_word = 32'(signed'(head_word));
								chain_op        = CHAIN_ROTATE;
								count_d         = count_q - 1'b1;
							end
						end
						REQ_POP_BACK: begin
							if (empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								rsp_load  = 1'b0;
								target_d  = IDX_W'(count_q - 1'b1);
								is_popb_d = 1'b1;
								state_d   = ST_SCAN;
							end
						end
						REQ_COUNT: begin
							rsp_load   = 1'b0;
							is_count_d = 1'b1;
							state_d    = ST_SCAN;
						end
						REQ_READ: begin
							if (CMP_W'(req.position) >= CMP_W'(count_q)) begin
								rsp_d.status = STATUS_BEYOND;
							end else begin
								rsp_load = 1'b0;
								target_d = IDX_W'(req.position);
								state_d  = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// a full turn of the ring brings entry step to cell 0, then restores it
				chain_op = CHAIN_ROTATE;
				if (!is_count_q && step_q == target_q) begin
					word_d = head_word;
				end
				if (is_count_q && CNT_W'(step_q) < count_q && head_word == val_q) begin
					acc_d = acc_q + 1'b1;
				end
				if (step_q == IDX_W'(DEPTH - 1)) begin
					state_d = ST_FLUSH;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_FLUSH: begin
				if (rsp_free) begin
					rsp_load          = 1'b1;
					rsp_d.read_word   = 32'(signed'(word_q));
					rsp_d.match_count = 6'(acc_q);
					if (is_popb_q) begin
						count_d = count_q - 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		rsp_d.occupancy = 6'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			is_count_q  <= 1'b0;
			is_popb_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			step_q     <= step_d;
			is_count_q <= is_count_d;
			is_popb_q  <= is_popb_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		target_q <= target_d;
		acc_q    <= acc_d;
		word_q   <= word_d;
		if (accept) begin
			val_q <= req_word;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded deque with value search
// Drives push, pop, count and read requests through the request channel and
// checks every response against a predictor that keeps its own ring of
// entries, front slot and entry count. Covers the empty and full edges, reads
// past the count, unused request codes, and a long random mix with idle
// bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
	import dbq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// request codes the block treats as no-ops
	localparam logic [2:0] REQ_UNUSED_A = 3'd6;
	localparam logic [2:0] REQ_UNUSED_B = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// predictor state
	logic signed [31:0] ring_word [DEPTH];
	logic [4:0]         head_slot;
	int                 held;

	rsp_item_t          pending_rsp[$];
	logic signed [31:0] word_pool [4];
	int                 mismatch_count;
	bit                 calm;

	bounded_deque_with_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [4:0] slot_at(input int offset);
		return head_slot + 5'(offset);
	endfunction

	// advance the predicted deque by one request and return its response
	function automatic rsp_item_t apply_request(input req_item_t r);
		rsp_item_t o;
		int        i;
		o = '0;
		case (r.req_type)
			REQ_PUSH_FRONT: begin
				if (held == DEPTH) begin
					o.status = STATUS_FULL;
				end else begin
					head_slot = head_slot - 5'd1;
					ring_word[head_slot] = r.data_word;
					held++;
				end
			end
			REQ_PUSH_BACK: begin
				if (held == DEPTH) begin
					o.status = STATUS_FULL;
				end else begin
					ring_word[slot_at(held)] = r.data_word;
					held++;
				end
			end
			REQ_POP_FRONT: begin
				if (held == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					o.read_word = ring_word[head_slot];
					head_slot = head_slot + 5'd1;
					held--;
				end
			end
			REQ_POP_BACK: begin
				if (held == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					o.read_word = ring_word[slot_at(held - 1)];
					held--;
				end
			end
			REQ_COUNT: begin
				for (i = 0; i < held; i++) begin
					if (ring_word[slot_at(i)] == r.data_word)
						o.match_count = o.match_count + 6'd1;
				end
			end
			REQ_READ: begin
				if (int'(r.position) >= held)
					o.status = STATUS_BEYOND;
				else
					o.read_word = ring_word[slot_at(int'(r.position))];
			end
			default: begin
			end
		endcase
		o.occupancy = 6'(held);
		return o;
	endfunction

	function automatic req_item_t make_req(input logic [2:0] code,
			input logic signed [31:0] word, input logic [4:0] pos);
		req_item_t r;
		r.req_type  = code;
		r.data_word = word;
		r.position  = pos;
		return r;
	endfunction

	// mix of fresh random words, extremes and a small pool so counts hit
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
			default: return word_pool[$urandom_range(0, 3)];
		endcase
	endfunction

	task automatic send_item(input req_item_t item);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(apply_request(item));
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// compare each response item against the oldest prediction
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("response with nothing outstanding");
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", 32'(rsp.status), 32'(want.status));
				check_field("read_word", rsp.read_word, want.read_word);
				check_field("match_count", 32'(rsp.match_count), 32'(want.match_count));
				check_field("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
			end
		end
	end

	// receiver: stall in random bursts unless the run has gone calm
	initial begin
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	task automatic test_edges_and_codes();
		send_item(make_req(REQ_POP_FRONT, 32'sd5, 5'd0));
		send_item(make_req(REQ_POP_BACK, -32'sd5, 5'd31));
		send_item(make_req(REQ_READ, 32'sd0, 5'd0));
		send_item(make_req(REQ_COUNT, 32'sd0, 5'd0));
		send_item(make_req(REQ_UNUSED_A, 32'sh7FFF_FFFF, 5'd31));
		send_item(make_req(REQ_UNUSED_B, 32'sh8000_0000, 5'd0));
		send_item(make_req(REQ_PUSH_FRONT, 32'sh8000_0000, 5'd0));
		send_item(make_req(REQ_PUSH_BACK, 32'sh7FFF_FFFF, 5'd31));
		send_item(make_req(REQ_PUSH_FRONT, -32'sd1, 5'd0));
		send_item(make_req(REQ_PUSH_BACK, 32'sd0, 5'd0));
		send_item(make_req(REQ_PUSH_BACK, 32'sh5A5A_A5A5, 5'd0));
		send_item(make_req(REQ_READ, 32'sd0, 5'd0));
		send_item(make_req(REQ_READ, 32'sd0, 5'd4));
		send_item(make_req(REQ_READ, 32'sd0, 5'd5));
		send_item(make_req(REQ_READ, -32'sd1, 5'd31));
		send_item(make_req(REQ_COUNT, -32'sd1, 5'd0));
		send_item(make_req(REQ_COUNT, 32'sd0, 5'd0));
		send_item(make_req(REQ_COUNT, 32'sd1234, 5'd0));
		send_item(make_req(REQ_UNUSED_B, -32'sd1, 5'd2));
		send_item(make_req(REQ_POP_BACK, 32'sd0, 5'd0));
		send_item(make_req(REQ_POP_FRONT, 32'sd0, 5'd0));
		send_item(make_req(REQ_POP_FRONT, 32'sd0, 5'd0));
		send_item(make_req(REQ_POP_BACK, 32'sd0, 5'd0));
		send_item(make_req(REQ_POP_BACK, 32'sd0, 5'd0));
		send_item(make_req(REQ_POP_FRONT, 32'sd0, 5'd0));
	endtask

	// fill with one value to reach a full match count, then push, read and drain
	task automatic test_full_store();
		logic signed [31:0] fill;
		fill = word_pool[0];
		while (held > 0)
			send_item(make_req(REQ_POP_FRONT, $urandom, 5'($urandom)));
		while (held < DEPTH) begin
			send_item(make_req($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
				fill, 5'($urandom)));
		end
		send_item(make_req(REQ_PUSH_FRONT, -32'sd1, 5'd0));
		send_item(make_req(REQ_PUSH_BACK, 32'sd1, 5'd31));
		send_item(make_req(REQ_COUNT, fill, 5'd0));
		send_item(make_req(REQ_COUNT, ~fill, 5'd0));
		send_item(make_req(REQ_READ, 32'sd0, 5'd0));
		send_item(make_req(REQ_READ, 32'sd0, 5'd31));
		while (held > 0) begin
			send_item(make_req($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
				$urandom, 5'($urandom)));
		end
		send_item(make_req(REQ_POP_BACK, 32'sd0, 5'd0));
		send_item(make_req(REQ_POP_FRONT, 32'sd0, 5'd0));
	endtask

	// weighted mix; the push/pop bias swings so the deque sweeps empty to full
	task automatic test_random_mix(input int n_items);
		req_item_t r;
		int        k;
		int        roll;
		int        fill_bias;
		fill_bias = 50;
		for (k = 0; k < n_items; k++) begin
			if (k % 48 == 0)
				fill_bias = $urandom_range(10, 90);
			r.data_word = pick_word();
			if (held == 0 || $urandom_range(0, 3) == 0)
				r.position = 5'($urandom);
			else
				r.position = 5'($urandom_range(0, held - 1));
			roll = $urandom_range(0, 99);
			if (roll < 4)
				r.req_type = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
			else if (roll < 20)
				r.req_type = REQ_COUNT;
			else if (roll < 34)
				r.req_type = REQ_READ;
			else if ($urandom_range(0, 99) < fill_bias)
				r.req_type = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				r.req_type = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
			send_item(r);
		end
	endtask

	// back-to-back traffic with both sides always ready
	task automatic test_steady_stream();
		calm = 1'b1;
		test_random_mix(80);
	endtask

	initial begin
		int k;
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		calm           = 1'b0;
		mismatch_count = 0;
		head_slot      = '0;
		held           = 0;
		for (k = 0; k < 4; k++)
			word_pool[k] = $urandom;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_edges_and_codes();
		test_full_store();
		test_random_mix(440);
		test_full_store();
		test_steady_stream();

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch("responses still outstanding");
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("status: fail");
		$finish;
	end

endmodule

### files.f
src/dbq_pkg.sv
src/dbq_cell.sv
src/dbq_chain.sv
src/bounded_deque_with_search.sv
dv/tb.sv
